### rtl/infix_expression_evaluator_unit_macros.svh
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define IEE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iee check failed: same-cycle implication");

// next-cycle implication, clocked on clk, off during reset
`define IEE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iee check failed: next-cycle implication");

`endif

### rtl/iee_pkg.sv
package iee_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      divide_error;
	} out_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
		logic div_fix;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic needs_mul;
		logic needs_div;
		logic last;
		logic iter_last;
	} status_t;

endpackage

### rtl/iee_ctrl.sv
module iee_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  iee_pkg::status_t st,
	output iee_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_DIV  = 5'b00100,
		S_DFIX = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   last_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept       = char_valid && (state_q == S_IDLE);
	assign out_free     = !out_valid_q || !result_stall;
	assign char_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.load     = accept;
		cmd.mul_step = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.div_fix  = (state_q == S_DFIX);
		cmd.finish   = (state_q == S_FIN) && out_free;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (st.needs_mul)
						state_d = S_MUL;
					else if (st.needs_div)
						state_d = S_DIV;
					else if (st.last)
						state_d = S_FIN;
				end
			end
			S_MUL: begin
				if (st.iter_last)
					state_d = last_q ? S_FIN : S_IDLE;
			end
			S_DIV: begin
				if (st.iter_last)
					state_d = S_DFIX;
			end
			S_DFIX: begin
				state_d = last_q ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				last_q <= st.last;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/iee_datapath.sv
module iee_datapath #(
	parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  iee_pkg::in_t     char_data,
	input  iee_pkg::cmd_t    cmd,
	output iee_pkg::status_t st,
	output iee_pkg::out_t    result_data
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] sum_q;
	logic [DATA_WIDTH-1:0] term_q;
	logic                  have_q;
	logic [DATA_WIDTH-1:0] num_q;
	logic [7:0]            op_q;
	logic                  err_q;

	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] opa_q;
	logic [DATA_WIDTH-1:0] opb_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      cnt_q;
	iee_pkg::out_t         result_q;

	logic                  is_digit;
	logic                  close;
	logic [DATA_WIDTH-1:0] digit_val;
	logic [DATA_WIDTH-1:0] num_next;
	logic [DATA_WIDTH-1:0] prev;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [DATA_WIDTH-1:0] mul_sum;
	logic [DATA_WIDTH:0]   div_shift;
	logic [DATA_WIDTH:0]   div_diff;
	logic [DATA_WIDTH-1:0] total;

	assign is_digit  = (char_data.character >= iee_pkg::CHAR_ZERO)
		&& (char_data.character <= iee_pkg::CHAR_NINE);
	assign close     = (!is_digit && (char_data.character != iee_pkg::CHAR_SPACE))
		|| char_data.end_of_text;
	assign digit_val = DATA_WIDTH'(char_data.character[3:0]);
	assign num_next  = is_digit ? ((num_q << 3) + (num_q << 1) + digit_val) : num_q;
	assign prev      = have_q ? term_q : '0;
	assign mag_a     = prev[DATA_WIDTH-1] ? (~prev + 1'b1) : prev;
	assign mag_b     = num_next[DATA_WIDTH-1] ? (~num_next + 1'b1) : num_next;
	assign mul_sum   = acc_q + (opb_q[0] ? opa_q : '0);
	assign div_shift = {acc_q, opb_q[DATA_WIDTH-1]};
	assign div_diff  = div_shift - {1'b0, opa_q};
	assign total     = sum_q + prev;

	assign st.needs_mul = close && (op_q == iee_pkg::CHAR_STAR);
	assign st.needs_div = close && (op_q == iee_pkg::CHAR_SLASH) && (num_next != '0);
	assign st.last      = char_data.end_of_text;
	assign st.iter_last = (cnt_q == '0);
	assign result_data  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			term_q <= '0;
			have_q <= 1'b0;
			num_q  <= '0;
			op_q   <= iee_pkg::CHAR_PLUS;
			err_q  <= 1'b0;
		end else if (cmd.finish) begin
			sum_q  <= '0;
			term_q <= '0;
			have_q <= 1'b0;
			num_q  <= '0;
			op_q   <= iee_pkg::CHAR_PLUS;
			err_q  <= 1'b0;
		end else if (cmd.load) begin
			if (close) begin
				case (op_q)
					iee_pkg::CHAR_PLUS: begin
						if (have_q)
							sum_q <= sum_q + term_q;
						term_q <= num_next;
						have_q <= 1'b1;
					end
					iee_pkg::CHAR_MINUS: begin
						if (have_q)
							sum_q <= sum_q + term_q;
						term_q <= ~num_next + 1'b1;
						have_q <= 1'b1;
					end
					iee_pkg::CHAR_SLASH: begin
						if (num_next == '0) begin
							err_q  <= 1'b1;
							term_q <= prev;
							have_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
				op_q  <= char_data.character;
				num_q <= '0;
			end else begin
				num_q <= num_next;
			end
		end else if (cmd.mul_step) begin
			if (cnt_q == '0) begin
				term_q <= mul_sum;
				have_q <= 1'b1;
			end
		end else if (cmd.div_fix) begin
			term_q <= neg_q ? (~opb_q + 1'b1) : opb_q;
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
			cnt_q <= CNT_W'(DATA_WIDTH - 1);
			if (op_q == iee_pkg::CHAR_SLASH) begin
				opa_q <= mag_b;
				opb_q <= mag_a;
				neg_q <= prev[DATA_WIDTH-1] ^ num_next[DATA_WIDTH-1];
			end else begin
				opa_q <= prev;
				opb_q <= num_next;
				neg_q <= 1'b0;
			end
		end else if (cmd.mul_step) begin
			acc_q <= mul_sum;
			opa_q <= opa_q << 1;
			opb_q <= opb_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.div_step) begin
			if (!div_diff[DATA_WIDTH]) begin
				acc_q <= div_diff[DATA_WIDTH-1:0];
				opb_q <= {opb_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				acc_q <= div_shift[DATA_WIDTH-1:0];
				opb_q <= {opb_q[DATA_WIDTH-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.finish) begin
			result_q.value        <= iee_pkg::VALUE_W'(total);
			result_q.divide_error <= err_q;
		end
	end

endmodule

### rtl/infix_expression_evaluator_unit.sv
// channel | signals                                 | moves
// input   | char_valid, char_stall, char_data       | one character per transaction
// output  | result_valid, result_stall, result_data | one result per expression
//
// Digit, space, + and - leave the input ready for the next character; closing a
// number after * or after / by a nonzero divisor runs one bit per cycle in the
// shared shift-add / restoring-divide unit; the final character adds a finish step.
// Reset clears the running sum, term, number, operator and error flag at once.
// A waiting result holds under result_stall; the next expression proceeds
// until its own final character needs the output register.
module infix_expression_evaluator_unit #(
	parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_stall,
	input  iee_pkg::in_t  char_data,
	output logic          result_valid,
	input  logic          result_stall,
	output iee_pkg::out_t result_data
);

	iee_pkg::cmd_t    cmd;
	iee_pkg::status_t st;

	iee_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.st           (st),
		.cmd          (cmd)
	);

	iee_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_data   (char_data),
		.cmd         (cmd),
		.st          (st),
		.result_data (result_data)
	);

endmodule

### rtl/iee_checker.sv
`include "infix_expression_evaluator_unit_macros.svh"

module iee_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          char_valid,
	input logic          char_stall,
	input iee_pkg::in_t  char_data,
	input logic          result_valid,
	input logic          result_stall,
	input iee_pkg::out_t result_data
);

	logic char_acc;
	logic char_last;
	logic char_mid;
	logic char_plain;
	logic result_held;

	assign char_acc    = char_valid && !char_stall;
	assign char_last   = char_acc && char_data.end_of_text;
	assign char_mid    = char_acc && !char_data.end_of_text;
	assign char_plain  = ((char_data.character >= iee_pkg::CHAR_ZERO)
		&& (char_data.character <= iee_pkg::CHAR_NINE))
		|| (char_data.character == iee_pkg::CHAR_SPACE);
	assign result_held = result_valid && result_stall;

	`IEE_ASSERT_NEXT(a_result_hold, result_held, result_valid && $stable(result_data))
	`IEE_ASSERT_NEXT(a_final_busy, char_last, char_stall)
	`IEE_ASSERT_NEXT(a_digit_one_cycle, char_mid && char_plain, !char_stall)
	`IEE_ASSERT_NEXT(a_no_spurious_result, char_mid, !$rose(result_valid))

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (.*);

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_CHARS = 1500;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	iee_pkg::in_t char_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	iee_pkg::out_t result_data;

	iee_pkg::out_t expected_totals[$];
	logic [31:0] sum_acc;
	logic [31:0] term_acc;
	logic term_live;
	logic [31:0] num_acc;
	logic [7:0] op_pending;
	logic div_err;

	int mismatches = 0;
	int chars_sent = 0;
	int burst_left = 0;
	bit quiet_stretch = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	infix_expression_evaluator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data(char_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string msg);
		if (mismatches < 50)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic clear_evaluator();
		sum_acc = '0;
		term_acc = '0;
		term_live = 1'b0;
		num_acc = '0;
		op_pending = iee_pkg::CHAR_PLUS;
		div_err = 1'b0;
	endtask

	task automatic evaluate_char(input iee_pkg::in_t item);
		logic is_digit;
		logic [31:0] prior;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] quo;
		iee_pkg::out_t res;
		is_digit = item.character >= iee_pkg::CHAR_ZERO
			&& item.character <= iee_pkg::CHAR_NINE;
		if (is_digit)
			num_acc = num_acc * 32'd10 + {24'd0, item.character - iee_pkg::CHAR_ZERO};
		if ((!is_digit && item.character != iee_pkg::CHAR_SPACE) || item.end_of_text) begin
			prior = term_live ? term_acc : '0;
			case (op_pending)
				iee_pkg::CHAR_PLUS, iee_pkg::CHAR_MINUS: begin
					if (term_live)
						sum_acc = sum_acc + term_acc;
					term_acc = (op_pending == iee_pkg::CHAR_MINUS) ? -num_acc : num_acc;
					term_live = 1'b1;
				end
				iee_pkg::CHAR_STAR: begin
					term_acc = prior * num_acc;
					term_live = 1'b1;
				end
				iee_pkg::CHAR_SLASH: begin
					if (num_acc == '0) begin
						div_err = 1'b1;
						term_acc = prior;
					end else begin
						mag_a = prior[31] ? -prior : prior;
						mag_b = num_acc[31] ? -num_acc : num_acc;
						quo = mag_a / mag_b;
						term_acc = (prior[31] ^ num_acc[31]) ? -quo : quo;
					end
					term_live = 1'b1;
				end
				default: ;
			endcase
			op_pending = item.character;
			num_acc = '0;
		end
		if (item.end_of_text) begin
			res.value = term_live ? sum_acc + term_acc : sum_acc;
			res.divide_error = div_err;
			expected_totals.push_back(res);
			clear_evaluator();
		end
	endtask

	task automatic send_char(input logic [7:0] ch, input logic eot);
		iee_pkg::in_t item;
		int gap;
		item.character = ch;
		item.end_of_text = eot;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = quiet_stretch ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		char_valid <= 1'b1;
		char_data <= item;
		do @(posedge clk); while (char_stall);
		burst_left--;
		chars_sent++;
		evaluate_char(item);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_operator();
		int roll;
		logic [7:0] ch;
		roll = $urandom_range(0, 19);
		if (roll < 6)
			return iee_pkg::CHAR_PLUS;
		if (roll < 10)
			return iee_pkg::CHAR_MINUS;
		if (roll < 14)
			return iee_pkg::CHAR_STAR;
		if (roll < 18)
			return iee_pkg::CHAR_SLASH;
		if (roll == 18)
			return iee_pkg::CHAR_SPACE;
		do ch = 8'($urandom_range(0, 255));
		while ((ch >= iee_pkg::CHAR_ZERO && ch <= iee_pkg::CHAR_NINE)
			|| ch == iee_pkg::CHAR_SPACE);
		return ch;
	endfunction

	task automatic send_random_expression();
		logic [7:0] text[$];
		logic [7:0] op;
		int terms;
		int len;
		op = iee_pkg::CHAR_PLUS;
		terms = $urandom_range(1, 6);
		for (int t = 0; t < terms; t++) begin
			if ($urandom_range(0, 7) == 0)
				text.push_back(iee_pkg::CHAR_SPACE);
			if (op == iee_pkg::CHAR_SLASH && $urandom_range(0, 4) == 0) begin
				text.push_back(iee_pkg::CHAR_ZERO);
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
				for (int d = 0; d < len; d++)
					text.push_back(iee_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 7) == 0)
				text.push_back(iee_pkg::CHAR_SPACE);
			if (t < terms - 1) begin
				op = pick_operator();
				text.push_back(op);
			end
		end
		if ($urandom_range(0, 3) == 0)
			text.push_back(pick_operator());
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++)
			send_char(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	task automatic test_empty_expression();
		send_text(" ");
	endtask

	task automatic test_wrap_and_min_over_minus_one();
		send_text("2147483648/4294967295");
	endtask

	task automatic test_divide_by_zero();
		send_text("7*8-6/0 ");
	endtask

	task automatic test_unknown_operator();
		send_text("3%4+2");
	endtask

	task automatic test_random_expressions();
		int target;
		target = chars_sent + RANDOM_CHARS;
		while (chars_sent < target) begin
			if ($urandom_range(0, 3) == 0)
				quiet_stretch = !quiet_stretch;
			if ($urandom_range(0, 6) == 0)
				send_noise();
			else
				send_random_expression();
		end
	endtask

	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (stall_phase % 5 < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_totals.size() == 0) begin
				report($sformatf("result with no expression pending, value %0d",
					result_data.value));
			end else begin
				if (result_data.value !== expected_totals[0].value)
					report($sformatf("value got %0d expected %0d",
						result_data.value, expected_totals[0].value));
				if (result_data.divide_error !== expected_totals[0].divide_error)
					report($sformatf("divide_error got %b expected %b",
						result_data.divide_error, expected_totals[0].divide_error));
				void'(expected_totals.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clear_evaluator();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_expression();
		test_wrap_and_min_over_minus_one();
		test_divide_by_zero();
		test_unknown_operator();
		test_random_expressions();

		@(negedge clk);
		char_valid <= 1'b0;
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
